@@ design/gef_pkg.sv @@
// ----------------------------------------------------------------------------
// Gradient edge filter package
// Shared types, register indexes, kernel mode codes and arithmetic constants.
// ----------------------------------------------------------------------------
package gef_pkg;

  // Widths of the fixed fields.
  localparam int PIX_W      = 8;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int MODE_W     = 2;
  localparam int GAIN_W     = 8;
  localparam int THR_W      = 9;
  localparam int RAW_W      = 14;  // |gx|+|gy| of the largest kernel stays below 2^14
  localparam int PROD_W     = 22;  // RAW_W + GAIN_W
  localparam int QUOT_W     = 20;  // PROD_W - 2 for the divide by four
  localparam int DIV3_W     = 19;  // product shifted down by three
  localparam int RECIP_W    = 20;
  localparam int RECIP_P_W  = DIV3_W + RECIP_W;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN           = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH     = 2'd3;

  // Kernel mode codes.
  localparam logic [MODE_W-1:0] MODE_PASS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CROSS  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SOBEL3 = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SOBEL4 = 2'd3;

  // Register reset values.
  localparam logic [MODE_W-1:0]     RST_KERNEL_MODE    = MODE_SOBEL3;
  localparam logic [GAIN_W-1:0]     RST_GAIN           = 8'd4;
  localparam logic [THR_W-1:0]      RST_EDGE_THRESHOLD = 9'd32;
  localparam logic [CFG_DATA_W-1:0] RST_LINE_WIDTH     = 11'd640;
  localparam logic [CFG_DATA_W-1:0] MIN_LINE_WIDTH     = 11'd4;

  // Output saturation level.
  localparam logic [PIX_W-1:0] EDGE_MAX = 8'd255;

  // ceil(2^21 / 3): (y * RECIP3) >> 21 equals y / 3 for every y below 2^21.
  localparam logic [RECIP_W-1:0] RECIP3 = 20'd699051;
  localparam int RECIP_SHIFT = 21;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [RAW_W-1:0] raw_t;
  typedef logic signed [RAW_W-1:0] sgrad_t;

  // Window: index [row][col], row 0 is the oldest line, col 3 the newest column.
  typedef pixel_t [3:0][3:0] win_t;

  // One line-store word: entry 0 is the newest line, entry 2 the oldest.
  typedef pixel_t [2:0] line_word_t;

  // Zero-extend a pixel into the signed gradient width.
  function automatic sgrad_t sext_pix(input pixel_t p);
    sext_pix = sgrad_t'({{(RAW_W-PIX_W){1'b0}}, p});
  endfunction

  // Absolute value of a gradient component.
  function automatic raw_t mag(input sgrad_t v);
    mag = (v < 0) ? raw_t'(-v) : raw_t'(v);
  endfunction

endpackage

@@ design/gradient_edge_filter.sv @@
// ----------------------------------------------------------------------------
// Gradient edge filter
// Streaming L1 gradient-magnitude edge detector over a 4x4 pixel window.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in_ channel (valid/ready); in_start_of_frame
// marks row 0, column 0 of a new image. Every pixel gives exactly one result
// item on the out_ channel: the gained, normalized, saturated and thresholded
// gradient (or the pixel itself in pass-through), its anchor position and a
// flag that is low for border windows, whose other fields are then zero.
// The cfg_ port writes kernel_mode, gain, edge_threshold and line_width; the
// user must write it only while no item is in flight; the block itself does
// not enforce this. Throughput is one item per cycle while the receiver takes
// items: the three line buffers sit in one memory word per column, read once
// when the pixel is accepted and written back when it leaves stage 1, with
// the written word forwarded when the next pixel hits the same column.
// Reset clears the pipeline, the position counters and the window and loads
// the register defaults; the line memory is not cleared. When the receiver
// stalls, the pipeline stages fill up and in_ready drops only once all four
// stages and the output register hold items; no item is lost or repeated.
// ----------------------------------------------------------------------------
module gradient_edge_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration port
  input  logic                               cfg_we,
  input  logic [gef_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gef_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [gef_pkg::PIX_W-1:0]          in_pixel,
  input  logic                               in_start_of_frame,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [gef_pkg::PIX_W-1:0]          out_edge_value,
  output logic [$clog2(MAX_WIDTH)-1:0]       out_anchor_col,
  output logic [$clog2(MAX_HEIGHT)-1:0]      out_anchor_row,
  output logic                               out_window_valid
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);

  // Configuration registers.
  logic [gef_pkg::MODE_W-1:0]     kernel_mode_r;
  logic [gef_pkg::GAIN_W-1:0]     gain_r;
  logic [gef_pkg::THR_W-1:0]      edge_threshold_r;
  logic [gef_pkg::CFG_DATA_W-1:0] line_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_mode_r    <= gef_pkg::RST_KERNEL_MODE;
      gain_r           <= gef_pkg::RST_GAIN;
      edge_threshold_r <= gef_pkg::RST_EDGE_THRESHOLD;
      line_width_r     <= gef_pkg::RST_LINE_WIDTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gef_pkg::REG_KERNEL_MODE:    kernel_mode_r    <= cfg_data[gef_pkg::MODE_W-1:0];
        gef_pkg::REG_GAIN:           gain_r           <= cfg_data[gef_pkg::GAIN_W-1:0];
        gef_pkg::REG_EDGE_THRESHOLD: edge_threshold_r <= cfg_data[gef_pkg::THR_W-1:0];
        default:                     line_width_r     <= cfg_data;
      endcase
    end
  end

  // Pipeline handshake: a stage loads whenever it is empty or its item moves on.
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic out_free, s4_free, s3_free, s2_free, s1_free;
  logic acc, s1_adv;

  assign out_free = !out_v_r || out_ready;
  assign s4_free  = !s4_v_r || out_free;
  assign s3_free  = !s3_v_r || s4_free;
  assign s2_free  = !s2_v_r || s3_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ready = s1_free;
  assign acc      = in_valid && in_ready;
  assign s1_adv   = s1_v_r && s2_free;

  // Effective line width, clamped to 4..MAX_WIDTH.
  logic [WID_W-1:0] width_eff;

  always_comb begin
    if (line_width_r < gef_pkg::MIN_LINE_WIDTH) begin
      width_eff = WID_W'(4);
    end else if ({21'd0, line_width_r} > 32'(MAX_WIDTH)) begin
      width_eff = WID_W'(MAX_WIDTH);
    end else begin
      width_eff = WID_W'(line_width_r);
    end
  end

  // Raster position of the accepted pixel and of the next one.
  logic [COL_W-1:0] col_r, col_nxt, cur_col;
  logic [ROW_W-1:0] row_r, row_nxt, cur_row;

  always_comb begin
    cur_col = in_start_of_frame ? '0 : col_r;
    cur_row = in_start_of_frame ? '0 : row_r;
    if (WID_W'(cur_col) + WID_W'(1) >= width_eff) begin
      col_nxt = '0;
      row_nxt = (cur_row == ROW_W'(MAX_HEIGHT - 1)) ? '0 : cur_row + ROW_W'(1);
    end else begin
      col_nxt = cur_col + COL_W'(1);
      row_nxt = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line memory: one word per column holding the three previous lines.
  gef_pkg::line_word_t line_mem [MAX_WIDTH];
  gef_pkg::line_word_t rd_data_r, fwd_data_r, line_cur, wr_data;
  logic                fwd_hit_r;

  logic [COL_W-1:0]   s1_col_r;
  logic [ROW_W-1:0]   s1_row_r;
  gef_pkg::pixel_t    s1_px_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_data_r <= line_mem[cur_col];
    end
    if (s1_adv) begin
      line_mem[s1_col_r] <= wr_data;
    end
  end

  // A write-back in the same cycle as a read of the same column is forwarded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (acc) begin
      fwd_hit_r <= s1_adv && (s1_col_r == cur_col);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fwd_data_r <= wr_data;
    end
  end

  // Stage 1 holds the accepted pixel while its line word is read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_px_r  <= in_pixel;
      s1_col_r <= cur_col;
      s1_row_r <= cur_row;
    end
  end

  assign line_cur = fwd_hit_r ? fwd_data_r : rd_data_r;
  assign wr_data  = {line_cur[1], line_cur[0], s1_px_r};

  // Window shift: columns move left, the new column enters on the right.
  gef_pkg::win_t win_r, win_nxt;

  always_comb begin
    for (int y = 0; y < 4; y++) begin
      for (int x = 0; x < 3; x++) begin
        win_nxt[y][x] = win_r[y][x+1];
      end
    end
    win_nxt[0][3] = line_cur[2];
    win_nxt[1][3] = line_cur[1];
    win_nxt[2][3] = line_cur[0];
    win_nxt[3][3] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_adv) begin
      win_r <= win_nxt;
    end
  end

  // Gradient magnitude of the updated window.
  gef_pkg::raw_t raw;

  gef_kernel u_kernel (
    .win  (win_nxt),
    .mode (kernel_mode_r),
    .raw  (raw)
  );

  // Border test and anchor position for the active kernel.
  logic             ok;
  logic [COL_W-1:0] acol;
  logic [ROW_W-1:0] arow;

  always_comb begin
    ok   = 1'b0;
    acol = '0;
    arow = '0;
    unique case (kernel_mode_r)
      gef_pkg::MODE_PASS: begin
        ok   = 1'b1;
        acol = s1_col_r;
        arow = s1_row_r;
      end
      gef_pkg::MODE_CROSS: begin
        if (s1_row_r >= ROW_W'(1) && s1_col_r >= COL_W'(1)) begin
          ok   = 1'b1;
          acol = s1_col_r - COL_W'(1);
          arow = s1_row_r - ROW_W'(1);
        end
      end
      gef_pkg::MODE_SOBEL3: begin
        if (s1_row_r >= ROW_W'(2) && s1_col_r >= COL_W'(2)) begin
          ok   = 1'b1;
          acol = s1_col_r - COL_W'(1);
          arow = s1_row_r - ROW_W'(1);
        end
      end
      default: begin
        if (s1_row_r >= ROW_W'(3) && s1_col_r >= COL_W'(3)) begin
          ok   = 1'b1;
          acol = s1_col_r - COL_W'(2);
          arow = s1_row_r - ROW_W'(2);
        end
      end
    endcase
  end

  // Stage 2: raw magnitude and item tags.
  gef_pkg::raw_t    s2_raw_r;
  gef_pkg::pixel_t  s2_px_r;
  logic             s2_ok_r;
  logic [COL_W-1:0] s2_acol_r;
  logic [ROW_W-1:0] s2_arow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_raw_r  <= raw;
      s2_px_r   <= s1_px_r;
      s2_ok_r   <= ok;
      s2_acol_r <= acol;
      s2_arow_r <= arow;
    end
  end

  // Stage 3: gain multiply.
  logic [gef_pkg::PROD_W-1:0] s3_prod_r;
  gef_pkg::pixel_t            s3_px_r;
  logic                       s3_ok_r;
  logic [COL_W-1:0]           s3_acol_r;
  logic [ROW_W-1:0]           s3_arow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_free) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free) begin
      s3_prod_r <= gef_pkg::PROD_W'(s2_raw_r) * gef_pkg::PROD_W'(gain_r);
      s3_px_r   <= s2_px_r;
      s3_ok_r   <= s2_ok_r;
      s3_acol_r <= s2_acol_r;
      s3_arow_r <= s2_arow_r;
    end
  end

  // Stage 4: kernel normalization (a divide by four for the cross, by eight for the 3x3 Sobel);
  // the divide by 24 of the 4x4 Sobel is a shift by three followed by a reciprocal multiply for the divide by three.
  logic [gef_pkg::DIV3_W-1:0]    div3_in;
  logic [gef_pkg::RECIP_P_W-1:0] div3_prod;
  logic [gef_pkg::QUOT_W-1:0]    quot;

  assign div3_in   = s3_prod_r[gef_pkg::PROD_W-1:3];
  assign div3_prod = gef_pkg::RECIP_P_W'(div3_in) * gef_pkg::RECIP_P_W'(gef_pkg::RECIP3);

  always_comb begin
    unique case (kernel_mode_r)
      gef_pkg::MODE_CROSS:  quot = s3_prod_r[gef_pkg::PROD_W-1:2];
      gef_pkg::MODE_SOBEL3: quot = gef_pkg::QUOT_W'(s3_prod_r[gef_pkg::PROD_W-1:3]);
      gef_pkg::MODE_SOBEL4: quot = gef_pkg::QUOT_W'(
                              div3_prod[gef_pkg::RECIP_P_W-1:gef_pkg::RECIP_SHIFT]);
      default:              quot = '0;
    endcase
  end

  logic [gef_pkg::QUOT_W-1:0] s4_quot_r;
  gef_pkg::pixel_t            s4_px_r;
  logic                       s4_ok_r;
  logic [COL_W-1:0]           s4_acol_r;
  logic [ROW_W-1:0]           s4_arow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s4_free) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_free) begin
      s4_quot_r <= quot;
      s4_px_r   <= s3_px_r;
      s4_ok_r   <= s3_ok_r;
      s4_acol_r <= s3_acol_r;
      s4_arow_r <= s3_arow_r;
    end
  end

  // Saturation, threshold and border zeroing into the output register.
  gef_pkg::pixel_t sat, edge_val;

  always_comb begin
    sat = (s4_quot_r > gef_pkg::QUOT_W'(gef_pkg::EDGE_MAX)) ? gef_pkg::EDGE_MAX
                                                          : s4_quot_r[gef_pkg::PIX_W-1:0];
    if (!s4_ok_r) begin
      edge_val = '0;
    end else if (kernel_mode_r == gef_pkg::MODE_PASS) begin
      edge_val = s4_px_r;
    end else if ({1'b0, sat} >= edge_threshold_r) begin
      edge_val = sat;
    end else begin
      edge_val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_edge_value   <= edge_val;
      out_anchor_col   <= s4_acol_r;
      out_anchor_row   <= s4_arow_r;
      out_window_valid <= s4_ok_r;
    end
  end

  assign out_valid = out_v_r;

endmodule

@@ design/gef_kernel.sv @@
// ----------------------------------------------------------------------------
// Gradient edge filter kernel
// Forms the L1 gradient magnitude |gx|+|gy| of one 4x4 window for the chosen
// kernel: 2x2 cross difference, 3x3 Sobel or 4x4 extended Sobel.
// ----------------------------------------------------------------------------
module gef_kernel (
  input  gef_pkg::win_t                    win,
  input  logic [gef_pkg::MODE_W-1:0]       mode,
  output gef_pkg::raw_t                    raw
);

  gef_pkg::sgrad_t hx [4];
  gef_pkg::sgrad_t vy [4];
  gef_pkg::sgrad_t gx4, gy4, gx3, gy3, dc1, dc2;

  // Row and column differences of the 4x4 window (right half minus left half,
  // lower half minus upper half).
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hx[i] = gef_pkg::sext_pix(win[i][2]) + gef_pkg::sext_pix(win[i][3])
            - gef_pkg::sext_pix(win[i][0]) - gef_pkg::sext_pix(win[i][1]);
      vy[i] = gef_pkg::sext_pix(win[2][i]) + gef_pkg::sext_pix(win[3][i])
            - gef_pkg::sext_pix(win[0][i]) - gef_pkg::sext_pix(win[1][i]);
    end
  end

  // Extended Sobel weights the inner rows and columns by two.
  assign gx4 = hx[0] + (hx[1] <<< 1) + (hx[2] <<< 1) + hx[3];
  assign gy4 = vy[0] + (vy[1] <<< 1) + (vy[2] <<< 1) + vy[3];

  // 3x3 Sobel on the lower-right 3x3 part of the window.
  assign gy3 = ((gef_pkg::sext_pix(win[3][2]) - gef_pkg::sext_pix(win[1][2])) <<< 1)
             + gef_pkg::sext_pix(win[3][1]) - gef_pkg::sext_pix(win[1][1])
             + gef_pkg::sext_pix(win[3][3]) - gef_pkg::sext_pix(win[1][3]);
  assign gx3 = ((gef_pkg::sext_pix(win[2][3]) - gef_pkg::sext_pix(win[2][1])) <<< 1)
             + gef_pkg::sext_pix(win[1][3]) - gef_pkg::sext_pix(win[1][1])
             + gef_pkg::sext_pix(win[3][3]) - gef_pkg::sext_pix(win[3][1]);

  // 2x2 cross difference on the lower-right 2x2 part of the window.
  assign dc1 = gef_pkg::sext_pix(win[3][2]) - gef_pkg::sext_pix(win[2][2])
             + gef_pkg::sext_pix(win[3][3]) - gef_pkg::sext_pix(win[2][3]);
  assign dc2 = gef_pkg::sext_pix(win[2][3]) - gef_pkg::sext_pix(win[2][2])
             + gef_pkg::sext_pix(win[3][3]) - gef_pkg::sext_pix(win[3][2]);

  // Select the magnitude of the active kernel.
  always_comb begin
    unique case (mode)
      gef_pkg::MODE_PASS:   raw = '0;
      gef_pkg::MODE_CROSS:  raw = gef_pkg::mag(dc1) + gef_pkg::mag(dc2);
      gef_pkg::MODE_SOBEL3: raw = gef_pkg::mag(gx3) + gef_pkg::mag(gy3);
      default:              raw = gef_pkg::mag(gx4) + gef_pkg::mag(gy4);
    endcase
  end

endmodule
